/* hw/rtl/tile_map_box_move_collision_defines.svh */
// Assertion macros shared by the tile map collision block.
`ifndef TILE_MAP_BOX_MOVE_COLLISION_DEFINES_SVH
`define TILE_MAP_BOX_MOVE_COLLISION_DEFINES_SVH

// Checked property, held off while reset is asserted.
`define TMBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked property, sampled during reset as well.
`define TMBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hw/rtl/tmbc_pkg.sv */
package tmbc_pkg;

  // Default store geometry and code width.
  localparam int unsigned MaxCols  = 256;
  localparam int unsigned MaxRows  = 64;
  localparam int unsigned CodeBits = 4;

  // A move step is an eighth of a tile.
  localparam int unsigned StepShift = 3;

  // Register reset values.
  localparam logic [2:0] TileShiftReset = 3'd4;
  localparam logic [8:0] MapWidthReset  = 9'd200;
  localparam logic [6:0] MapHeightReset = 7'd64;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_TILE_SHIFT = 2'd0,
    CFG_MAP_WIDTH  = 2'd1,
    CFG_MAP_HEIGHT = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_e;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_MOVE_X = 2'd2,
    OP_MOVE_Y = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [7:0]         tile_col;
    logic [5:0]         tile_row;
    logic [3:0]         tile_code;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic [7:0]         box_w;
    logic [7:0]         box_h;
    logic signed [15:0] delta;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  read_code;
    logic [15:0] new_coord;
    logic        hit;
  } out_item_t;

  // Tile index of a pixel coordinate; a negative coordinate truncates to tile zero.
  function automatic logic [13:0] tile_of(logic signed [17:0] v, logic [2:0] s);
    logic [16:0] u;
    u = v[16:0] >> s;
    return v[17] ? 14'd0 : u[13:0];
  endfunction

endpackage

/* hw/rtl/tile_map_box_move_collision.sv */
// A write passes IDLE and FINISH; a read IDLE, RDWAIT and FINISH (no RDWAIT outside the
// store). A move passes LOOP and PSET per leading-edge test, TADDR and TCHK per tile read
// (TADDR alone per tile off the map) and SNAP on a hit. One item at a time; the single
// read port tests one tile at a time. Reset: asynchronous, active low; the tile store is
// then cleared one entry per cycle, all 2**(clog2(MAX_COLS)+clog2(MAX_ROWS)) entries
// (16384 by default), with input stalled. Registers return to shift 4, width 200, height 64.
`include "tile_map_box_move_collision_defines.svh"

module tile_map_box_move_collision #(
  parameter int unsigned MAX_COLS  = tmbc_pkg::MaxCols,
  parameter int unsigned MAX_ROWS  = tmbc_pkg::MaxRows,
  parameter int unsigned CODE_BITS = tmbc_pkg::CodeBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [8:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tmbc_pkg::in_item_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tmbc_pkg::out_item_t out_data_o
);

  localparam int unsigned CB    = $clog2(MAX_COLS);
  localparam int unsigned RB    = $clog2(MAX_ROWS);
  localparam int unsigned AW    = CB + RB;
  localparam int unsigned Depth = 2 ** AW;

  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_RDWAIT = 9'b000000100,
    ST_LOOP   = 9'b000001000,
    ST_PSET   = 9'b000010000,
    ST_TADDR  = 9'b000100000,
    ST_TCHK   = 9'b001000000,
    ST_SNAP   = 9'b010000000,
    ST_FINISH = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [2:0] tile_shift_q;
  logic [8:0] map_width_q;
  logic [6:0] map_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_shift_q <= tmbc_pkg::TileShiftReset;
      map_width_q  <= tmbc_pkg::MapWidthReset;
      map_height_q <= tmbc_pkg::MapHeightReset;
    end else if (cfg_we_i) begin
      unique case (tmbc_pkg::cfg_idx_e'(cfg_idx_i))
        tmbc_pkg::CFG_TILE_SHIFT: tile_shift_q <= cfg_data_i[2:0];
        tmbc_pkg::CFG_MAP_WIDTH:  map_width_q  <= cfg_data_i;
        tmbc_pkg::CFG_MAP_HEIGHT: map_height_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Effective tile shift, step and map bounds.
  logic [2:0]  shift;
  logic [3:0]  step_mag;
  logic [6:0]  tile_m1;
  logic [15:0] w_eff;
  logic [15:0] h_eff;

  always_comb begin
    if (tile_shift_q < 3'd3) begin
      shift = 3'd3;
    end else if (tile_shift_q > 3'd6) begin
      shift = 3'd6;
    end else begin
      shift = tile_shift_q;
    end
    step_mag = 4'(4'd1 << (shift - 3'(tmbc_pkg::StepShift)));
    tile_m1  = 7'((7'd1 << shift) - 7'd1);
    w_eff    = (32'(map_width_q) > MAX_COLS) ? 16'(MAX_COLS) : 16'(map_width_q);
    h_eff    = (32'(map_height_q) > MAX_ROWS) ? 16'(MAX_ROWS) : 16'(map_height_q);
  end

  // Tile store with one write and one registered read port.
  logic [CODE_BITS-1:0] mem_q [Depth];
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [CODE_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [CODE_BITS-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  // Working registers of the walk.
  logic [AW-1:0]      clr_q, clr_d;
  logic               vert_q, vert_d;
  logic               fwd_q, fwd_d;
  logic               neg_q, neg_d;
  logic               final_q, final_d;
  logic               hit_q, hit_d;
  logic signed [17:0] pos_q, pos_d;
  logic [15:0]        end_q, end_d;
  logic [15:0]        oth_q, oth_d;
  logic [7:0]         len_q, len_d;
  logic [7:0]         span_q, span_d;
  logic [13:0]        k_q, k_d;
  logic [13:0]        hi_q, hi_d;
  logic [13:0]        lead_q, lead_d;
  logic [3:0]         code_q, code_d;
  logic               out_valid_q, out_valid_d;
  tmbc_pkg::out_item_t out_q, out_d;

  logic               accept;
  logic               probe_done;
  logic               probe_hit;
  logic signed [17:0] step_s;
  logic signed [17:0] end_raw;
  logic signed [17:0] lead_v;
  logic signed [17:0] hi_v;
  logic [13:0]        col;
  logic [13:0]        row;
  logic               outside;
  logic [16:0]        snap_num;
  logic [16:0]        snap_val;
  logic [15:0]        in_start;
  logic [7:0]         code8;
  logic [7:0]         rd8;
  logic [15:0]        in_col;
  logic [15:0]        in_row;
  logic               in_range;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    code8    = 8'(in_data_i.tile_code);
    rd8      = 8'(rd_q);
    in_col   = 16'(in_data_i.tile_col);
    in_row   = 16'(in_data_i.tile_row);
    in_range = (32'(in_col) < MAX_COLS) && (32'(in_row) < MAX_ROWS);
    in_start = (in_data_i.operation == tmbc_pkg::OP_MOVE_Y) ? in_data_i.pos_y
                                                            : in_data_i.pos_x;
    end_raw  = $signed({2'b00, in_start}) + 18'(in_data_i.delta);
    if (in_data_i.delta == 16'sd0) begin
      step_s = 18'sd0;
    end else if (in_data_i.delta[15]) begin
      step_s = -$signed({14'd0, step_mag});
    end else begin
      step_s = $signed({14'd0, step_mag});
    end
    // Leading edge tile and the far end of the span across the move.
    if (fwd_q) begin
      lead_v = pos_q + $signed({10'd0, len_q}) - 18'sd1;
    end else if (vert_q) begin
      lead_v = pos_q - 18'sd1;
    end else begin
      lead_v = pos_q;
    end
    hi_v     = $signed({2'b00, oth_q}) + $signed({10'd0, span_q}) - 18'sd1;
    col      = vert_q ? k_q : lead_q;
    row      = vert_q ? lead_q : k_q;
    outside  = ({2'b00, col} >= w_eff) || ({2'b00, row} >= h_eff);
    snap_num = 17'(pos_q) + (neg_q ? 17'(tile_m1) : 17'd0);
    snap_val = (snap_num >> shift) << shift;
  end

  // Sequencer: one tile test at a time through the store's single read port.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    vert_d      = vert_q;
    fwd_d       = fwd_q;
    neg_d       = neg_q;
    final_d     = final_q;
    hit_d       = hit_q;
    pos_d       = pos_q;
    end_d       = end_q;
    oth_d       = oth_q;
    len_d       = len_q;
    span_d      = span_q;
    k_d         = k_q;
    hi_d        = hi_q;
    lead_d      = lead_q;
    code_d      = code_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = clr_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = {row[RB-1:0], col[CB-1:0]};
    probe_done  = 1'b0;
    probe_hit   = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (clr_q == AW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          code_d = 4'd0;
          hit_d  = 1'b0;
          pos_d  = 18'sd0;
          unique case (tmbc_pkg::op_e'(in_data_i.operation))
            tmbc_pkg::OP_WRITE: begin
              mem_we    = in_range;
              mem_waddr = {in_row[RB-1:0], in_col[CB-1:0]};
              mem_wdata = code8[CODE_BITS-1:0];
              state_d   = ST_FINISH;
            end
            tmbc_pkg::OP_READ: begin
              mem_re    = in_range;
              mem_raddr = {in_row[RB-1:0], in_col[CB-1:0]};
              state_d   = in_range ? ST_RDWAIT : ST_FINISH;
            end
            default: begin
              vert_d = (in_data_i.operation == tmbc_pkg::OP_MOVE_Y);
              fwd_d  = !in_data_i.delta[15] && (in_data_i.delta != 16'sd0);
              neg_d  = in_data_i.delta[15];
              oth_d  = vert_d ? in_data_i.pos_x : in_data_i.pos_y;
              len_d  = vert_d ? in_data_i.box_h : in_data_i.box_w;
              span_d = vert_d ? in_data_i.box_w : in_data_i.box_h;
              if (end_raw < 18'sd0) begin
                end_d = 16'd0;
              end else if (end_raw > 18'sd65535) begin
                end_d = 16'hFFFF;
              end else begin
                end_d = end_raw[15:0];
              end
              pos_d   = $signed({2'b00, in_start}) + step_s;
              state_d = ST_LOOP;
            end
          endcase
        end
      end
      ST_RDWAIT: begin
        code_d  = rd8[3:0];
        state_d = ST_FINISH;
      end
      ST_LOOP: begin
        // Step while short of the target, else a last test at the target.
        if (fwd_q ? (pos_q < $signed({2'b00, end_q}))
                  : (pos_q > $signed({2'b00, end_q}))) begin
          final_d = 1'b0;
        end else begin
          final_d = 1'b1;
          pos_d   = $signed({2'b00, end_q});
        end
        state_d = ST_PSET;
      end
      ST_PSET: begin
        lead_d = tmbc_pkg::tile_of(lead_v, shift);
        k_d    = tmbc_pkg::tile_of($signed({2'b00, oth_q}), shift);
        hi_d   = tmbc_pkg::tile_of(hi_v, shift);
        if (hi_v < 18'sd0 || k_d <= hi_d) begin
          state_d = ST_TADDR;
        end else begin
          probe_done = 1'b1;
        end
      end
      ST_TADDR: begin
        if (outside) begin
          probe_done = 1'b1;
          probe_hit  = 1'b1;
        end else begin
          mem_re  = 1'b1;
          state_d = ST_TCHK;
        end
      end
      ST_TCHK: begin
        if (rd_q != '0) begin
          probe_done = 1'b1;
          probe_hit  = 1'b1;
        end else if (k_q == hi_q) begin
          probe_done = 1'b1;
        end else begin
          k_d     = k_q + 14'd1;
          state_d = ST_TADDR;
        end
      end
      ST_SNAP: begin
        pos_d   = (snap_val > 17'd65535) ? 18'sd65535 : $signed({1'b0, snap_val});
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d     = 1'b1;
          out_d.read_code = code_q;
          out_d.new_coord = pos_q[15:0];
          out_d.hit       = hit_q;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Close a tile test: a step walk advances once more, even after a hit.
    if (probe_done) begin
      if (!final_q) begin
        pos_d = pos_q + (neg_q ? -$signed({14'd0, step_mag})
                               : $signed({14'd0, step_mag}));
      end
      hit_d = probe_hit;
      if (probe_hit) begin
        state_d = ST_SNAP;
      end else if (final_q) begin
        state_d = ST_FINISH;
      end else begin
        state_d = ST_LOOP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vert_q  <= vert_d;
    fwd_q   <= fwd_d;
    neg_q   <= neg_d;
    final_q <= final_d;
    hit_q   <= hit_d;
    pos_q   <= pos_d;
    end_q   <= end_d;
    oth_q   <= oth_d;
    len_q   <= len_d;
    span_q  <= span_d;
    k_q     <= k_d;
    hi_q    <= hi_d;
    lead_q  <= lead_d;
    code_q  <= code_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // No result leaves while the store is still being cleared.
  `TMBC_ASSERT(a_no_out_in_clear, state_q == ST_CLEAR |-> !out_valid_o, "result during clear")
  // A snap only follows a hit.
  `TMBC_ASSERT(a_snap_hit, state_q == ST_SNAP |-> hit_q, "snap without hit")
  // The tile scan never runs past the end of its span.
  `TMBC_ASSERT(a_scan_bound, state_q == ST_TCHK |-> k_q <= hi_q, "scan past span")

endmodule

/* tb/tile_map_box_move_collision_tb.sv */
`timescale 1ns / 1ps

module tile_map_box_move_collision_tb;

  localparam int unsigned CycleLimit = 40_000_000;
  localparam int unsigned StoreDepth = 256 * 64;

  // Software copy of the tile map and its collision walk; it queues the
  // result that each accepted transfer must produce.
  class tile_map_scoreboard;
    int unsigned         tile_shift_q;
    int unsigned         map_width_q;
    int unsigned         map_height_q;
    logic [3:0]          tiles[StoreDepth];
    tmbc_pkg::out_item_t due_q[$];
    int unsigned         errors;

    function void clear();
      foreach (tiles[i]) tiles[i] = '0;
      tile_shift_q = 32'(tmbc_pkg::TileShiftReset);
      map_width_q  = 32'(tmbc_pkg::MapWidthReset);
      map_height_q = 32'(tmbc_pkg::MapHeightReset);
      errors       = 0;
    endfunction

    function void set_reg(tmbc_pkg::cfg_idx_e idx, logic [8:0] value);
      case (idx)
        tmbc_pkg::CFG_TILE_SHIFT: tile_shift_q = 32'(value[2:0]);
        tmbc_pkg::CFG_MAP_WIDTH:  map_width_q  = 32'(value[8:0]);
        tmbc_pkg::CFG_MAP_HEIGHT: map_height_q = 32'(value[6:0]);
        default: ;
      endcase
    endfunction

    // Tile edge in pixels, with the shift held to 3..6.
    function int tile_px();
      int unsigned s;
      s = tile_shift_q;
      if (s < 3) s = 3;
      if (s > 6) s = 6;
      return 1 << s;
    endfunction

    // Anything outside the map in use is a wall.
    function bit is_wall(int c, int r);
      int w;
      int h;
      w = (map_width_q > 256) ? 256 : int'(map_width_q);
      h = (map_height_q > 64) ? 64 : int'(map_height_q);
      if (c < 0 || r < 0 || c >= w || r >= h) return 1'b1;
      return tiles[r * 256 + c] != 0;
    endfunction

    // Tests the row or column of tiles under the leading edge of the box.
    function bit edge_blocked(bit vert, bit fwd, int p, int q, int len, int span, int t);
      int lead;
      int lo;
      int hi;
      if (fwd) lead = (p + len - 1) / t;
      else lead = vert ? (p - 1) / t : p / t;
      lo = q / t;
      hi = (q + span - 1) / t;
      for (int k = lo; k <= hi; k++) begin
        if (vert ? is_wall(k, lead) : is_wall(lead, k)) return 1'b1;
      end
      return 1'b0;
    endfunction

    // Walks the box in eighth-tile steps and snaps it on a collision.
    function void walk_box(input bit vert, input int start, input int q, input int len,
                           input int span, input int disp, output int coord,
                           output bit blocked);
      int  t;
      int  step;
      int  target;
      int  pos;
      bit  fwd;
      t       = tile_px();
      step    = (t >> tmbc_pkg::StepShift) * ((disp > 0) ? 1 : ((disp < 0) ? -1 : 0));
      target  = start + disp;
      fwd     = disp > 0;
      blocked = 1'b0;
      if (target < 0) target = 0;
      if (target > 65535) target = 65535;
      pos = start + step;
      while ((fwd ? (pos < target) : (pos > target)) && !blocked) begin
        blocked = edge_blocked(vert, fwd, pos, q, len, span, t);
        pos += step;
      end
      if (!blocked) begin
        pos     = target;
        blocked = edge_blocked(vert, fwd, pos, q, len, span, t);
      end
      if (blocked) pos = ((pos + ((disp < 0) ? t - 1 : 0)) / t) * t;
      if (pos < 0) pos = 0;
      if (pos > 65535) pos = 65535;
      coord = pos;
    endfunction

    function void note_input(tmbc_pkg::in_item_t it);
      tmbc_pkg::out_item_t res;
      int                  coord;
      bit                  blocked;
      res = '0;
      case (tmbc_pkg::op_e'(it.operation))
        tmbc_pkg::OP_WRITE: tiles[it.tile_row * 256 + it.tile_col] = it.tile_code;
        tmbc_pkg::OP_READ:  res.read_code = tiles[it.tile_row * 256 + it.tile_col];
        tmbc_pkg::OP_MOVE_X: begin
          walk_box(1'b0, int'(it.pos_x), int'(it.pos_y), int'(it.box_w), int'(it.box_h),
                   int'($signed(it.delta)), coord, blocked);
          res.new_coord = coord[15:0];
          res.hit       = blocked;
        end
        default: begin
          walk_box(1'b1, int'(it.pos_y), int'(it.pos_x), int'(it.box_h), int'(it.box_w),
                   int'($signed(it.delta)), coord, blocked);
          res.new_coord = coord[15:0];
          res.hit       = blocked;
        end
      endcase
      due_q = {due_q, res};
    endfunction

    function void check_result(tmbc_pkg::out_item_t got);
      tmbc_pkg::out_item_t want;
      if (due_q.size() == 0) begin
        $error("result transfer with nothing outstanding: %h", got);
        errors++;
        return;
      end
      want = due_q.pop_front();
      if (got.read_code !== want.read_code) begin
        $error("read_code: expected %0d, actual %0d", want.read_code, got.read_code);
        errors++;
      end
      if (got.new_coord !== want.new_coord) begin
        $error("new_coord: expected %0d, actual %0d", want.new_coord, got.new_coord);
        errors++;
      end
      if (got.hit !== want.hit) begin
        $error("hit: expected %0d, actual %0d", want.hit, got.hit);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_idx_i = '0;
  logic [8:0]          cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  tmbc_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  tmbc_pkg::out_item_t out_data_o;

  tile_map_scoreboard map_sb;
  int unsigned        cycle_count = 0;
  int unsigned        rx_hold = 0;
  bit                 tx_quiet = 1'b0;
  bit                 rx_quiet = 1'b0;

  tile_map_box_move_collision dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: check each transfer and choose the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) map_sb.check_result(out_data_o);
    if (rx_hold > 0) begin
      rx_hold     <= rx_hold - 1;
      out_stall_i <= 1'b1;
    end else if (!rx_quiet && $urandom_range(0, 99) < 10) begin
      rx_hold     <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Presents one item and holds it until the block takes it.
  task automatic send_item(tmbc_pkg::in_item_t it);
    int unsigned gap;
    gap = 0;
    if (!tx_quiet && $urandom_range(0, 99) < 30)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    map_sb.note_input(it);
  endtask

  // Waits until every outstanding result has been seen.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (map_sb.due_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(tmbc_pkg::cfg_idx_e idx, logic [8:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    map_sb.set_reg(idx, value);
  endtask

  task automatic set_map(logic [8:0] shift, logic [8:0] width, logic [8:0] height);
    drain();
    write_reg(tmbc_pkg::CFG_TILE_SHIFT, shift);
    write_reg(tmbc_pkg::CFG_MAP_WIDTH, width);
    write_reg(tmbc_pkg::CFG_MAP_HEIGHT, height);
    @(posedge clk_i);
  endtask

  function automatic tmbc_pkg::in_item_t make_item(tmbc_pkg::op_e op, int col, int row,
                                                   int code, int px, int py, int bw,
                                                   int bh, int disp);
    tmbc_pkg::in_item_t it;
    it           = '0;
    it.operation = op;
    it.tile_col  = 8'(col);
    it.tile_row  = 6'(row);
    it.tile_code = 4'(code);
    it.pos_x     = 16'(px);
    it.pos_y     = 16'(py);
    it.box_w     = 8'(bw);
    it.box_h     = 8'(bh);
    it.delta     = 16'(disp);
    return it;
  endfunction

  // Random item: mostly moves of modest reach around the map in use, with the
  // odd full-range position, size or displacement.
  function automatic tmbc_pkg::in_item_t random_item();
    tmbc_pkg::in_item_t it;
    logic [95:0]        raw;
    int unsigned        sel;
    int unsigned        span_x;
    int unsigned        span_y;
    int                 t;
    raw    = {$urandom, $urandom, $urandom};
    it     = raw[$bits(tmbc_pkg::in_item_t)-1:0];
    t      = map_sb.tile_px();
    span_x = ((map_sb.map_width_q > 256) ? 256 : map_sb.map_width_q) * t;
    span_y = ((map_sb.map_height_q > 64) ? 64 : map_sb.map_height_q) * t;
    sel    = $urandom_range(0, 99);
    if (sel < 25) begin
      it.operation = tmbc_pkg::OP_WRITE;
      if ($urandom_range(0, 2) != 0) it.tile_code = '0;
    end else if (sel < 42) begin
      it.operation = tmbc_pkg::OP_READ;
    end else begin
      it.operation = (sel < 71) ? tmbc_pkg::OP_MOVE_X : tmbc_pkg::OP_MOVE_Y;
      if ($urandom_range(0, 19) != 0) begin
        it.pos_x = 16'($urandom_range(0, (span_x + 64 > 65535) ? 65535 : span_x + 64));
        it.pos_y = 16'($urandom_range(0, (span_y + 64 > 65535) ? 65535 : span_y + 64));
      end
      if ($urandom_range(0, 39) != 0) begin
        it.box_w = 8'($urandom_range(0, 48));
        it.box_h = 8'($urandom_range(0, 48));
      end
      sel = $urandom_range(0, 29);
      if (sel == 0) it.delta = '0;
      else if (sel != 1) it.delta = 16'($urandom_range(0, 600) - 300);
    end
    return it;
  endfunction

  task automatic run_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_item(random_item());
      if (i == count / 2 && $urandom_range(0, 1) == 1) drain();
    end
  endtask

  initial begin
    map_sb = new();
    map_sb.clear();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, run against the reset register values.
    set_map(9'd4, 9'd200, 9'd64);
    send_item(make_item(tmbc_pkg::OP_WRITE, 0, 0, 15, 0, 0, 1, 1, 0));
    send_item(make_item(tmbc_pkg::OP_WRITE, 255, 63, 1, 0, 0, 1, 1, 0));
    send_item(make_item(tmbc_pkg::OP_READ, 0, 0, 0, 0, 0, 1, 1, 0));
    send_item(make_item(tmbc_pkg::OP_READ, 255, 63, 0, 0, 0, 1, 1, 0));
    send_item(make_item(tmbc_pkg::OP_READ, 7, 7, 0, 0, 0, 1, 1, 0));
    send_item(make_item(tmbc_pkg::OP_WRITE, 0, 0, 0, 0, 0, 1, 1, 0));
    send_item(make_item(tmbc_pkg::OP_READ, 0, 0, 0, 0, 0, 1, 1, 0));
    send_item(make_item(tmbc_pkg::OP_WRITE, 10, 5, 9, 0, 0, 1, 1, 0));
    // Moves into the solid tile at column 10, row 5 from each side.
    send_item(make_item(tmbc_pkg::OP_MOVE_X, 0, 0, 0, 100, 84, 12, 8, 100));
    send_item(make_item(tmbc_pkg::OP_MOVE_X, 0, 0, 0, 250, 84, 12, 8, -100));
    send_item(make_item(tmbc_pkg::OP_MOVE_Y, 0, 0, 0, 164, 20, 8, 12, 100));
    send_item(make_item(tmbc_pkg::OP_MOVE_Y, 0, 0, 0, 164, 150, 8, 12, -100));
    // A box already against the wall does not move, tested in place.
    send_item(make_item(tmbc_pkg::OP_MOVE_X, 0, 0, 0, 176, 84, 8, 8, 0));
    send_item(make_item(tmbc_pkg::OP_MOVE_Y, 0, 0, 0, 164, 96, 8, 8, 0));
    // Empty spans from a zero box size.
    send_item(make_item(tmbc_pkg::OP_MOVE_X, 0, 0, 0, 100, 84, 12, 0, 40));
    send_item(make_item(tmbc_pkg::OP_MOVE_Y, 0, 0, 0, 164, 20, 0, 12, 40));
    // Targets saturated at both ends of the coordinate range, then a move off the map's right edge.
    send_item(make_item(tmbc_pkg::OP_MOVE_X, 0, 0, 0, 0, 30, 255, 255, -32768));
    send_item(make_item(tmbc_pkg::OP_MOVE_Y, 0, 0, 0, 30, 65535, 255, 255, 32767));
    send_item(make_item(tmbc_pkg::OP_MOVE_X, 0, 0, 0, 65535, 0, 1, 1, 32767));
    send_item(make_item(tmbc_pkg::OP_MOVE_Y, 0, 0, 0, 0, 20, 1, 1, -32768));
    send_item(make_item(tmbc_pkg::OP_MOVE_X, 0, 0, 0, 3190, 16, 4, 4, 300));

    // Random part across several map settings, extremes among them.
    run_random(200);
    set_map(9'd3, 9'd256, 9'd64);
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    run_random(200);
    set_map(9'd6, 9'd1, 9'd1);
    tx_quiet = 1'b0;
    run_random(150);
    set_map(9'd7, 9'd511, 9'd127);
    rx_quiet = 1'b0;
    run_random(200);
    set_map(9'd0, 9'd0, 9'd0);
    run_random(100);
    set_map(9'd5, 9'd100, 9'd32);
    run_random(200);
    set_map(9'd4, 9'd200, 9'd64);
    run_random(150);

    drain();
    repeat (20) @(posedge clk_i);
    if (map_sb.due_q.size() != 0) begin
      $error("%0d results never arrived", map_sb.due_q.size());
      map_sb.errors++;
    end
    if (map_sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/tmbc_pkg.sv
hw/rtl/tile_map_box_move_collision.sv
tb/tile_map_box_move_collision_tb.sv
